// ===== hdl/sga_pkg.sv =====
// ----------------------------------------------------------------------------
// sga_pkg
// Shared constants, request/response types and helpers for the static
// gravity alignment block.
// ----------------------------------------------------------------------------
`default_nettype none

package sga_pkg;

  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned MIN_SAMPLES = 10;

  localparam int CNT_W  = 13;
  localparam int SUM_W  = 29;
  localparam int SQS_W  = 45;
  localparam int ABS_W  = 28;
  localparam int S2_W   = 56;
  localparam int LHS_W  = 58;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 64;
  localparam int DIV_DW = 48;
  localparam int DIV_VW = 32;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FEW    = 2'd1;
  localparam logic [1:0] STATUS_MOVING = 2'd2;

  localparam logic CFG_SAMPLE_LIMIT   = 1'b0;
  localparam logic CFG_VARIANCE_LIMIT = 1'b1;

  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic signed [15:0] ALIGN_MIN  = 16'sd16383;
  localparam logic signed [15:0] OPPOSE_MAX = -16'sd16383;
  localparam logic [15:0]        TILT_MAX   = 16'd14745;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [15:0] clamp_q14(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd16384) begin
      r = ONE_Q14;
    end else if (v < -32'sd16384) begin
      r = -ONE_Q14;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/static_gravity_alignment.sv =====
// ----------------------------------------------------------------------------
// static_gravity_alignment
// Batch accelerometer averaging, stillness test and gravity-to-Z rotation.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Each
// request carries one accelerometer sample and the batch_end flag. The
// first min(sample_limit, 4096) samples of a batch are summed; later ones
// are dropped. A summed sample keeps busy high while one shared multiplier
// squares x, y and z in turn; a dropped one leaves busy low unless it ends
// the batch. On batch_end the block runs its answer: a too-few verdict is
// strobed from the count check and a moving verdict from the stillness test.
// An accepted batch then runs up to two 32-step square roots and several
// 48-step divisions on one shared divider, the most when gravity
// points down -Z (nine for the rotation). Results leave on result_valid for one
// cycle each: one result for a short verdict, three rows for an accepted
// batch, final_row on the last. The receiver cannot stall. Reset restores
// the register defaults and clears the accumulators; configuration writes
// go through cfg_write, cfg_index and cfg_data and take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module static_gravity_alignment import sga_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire signed [15:0]  accel_x,
  input  wire signed [15:0]  accel_y,
  input  wire signed [15:0]  accel_z,
  input  wire                batch_end,
  input  wire                cfg_write,
  input  wire                cfg_index,
  input  wire        [31:0]  cfg_data,
  output logic               result_valid,
  output logic        [1:0]  status,
  output logic       [15:0]  magnitude,
  output logic        [1:0]  row_index,
  output logic signed [15:0] gravity_part,
  output logic signed [15:0] rot_col0,
  output logic signed [15:0] rot_col1,
  output logic signed [15:0] rot_col2,
  output logic               final_row
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ACC   = 5'd1;
  localparam logic [4:0] ST_CHECK = 5'd2;
  localparam logic [4:0] ST_VSQ   = 5'd3;
  localparam logic [4:0] ST_NS0   = 5'd4;
  localparam logic [4:0] ST_NS1   = 5'd5;
  localparam logic [4:0] ST_NS2   = 5'd6;
  localparam logic [4:0] ST_NS3   = 5'd7;
  localparam logic [4:0] ST_VCMP  = 5'd8;
  localparam logic [4:0] ST_MSQRT = 5'd9;
  localparam logic [4:0] ST_MDIV  = 5'd10;
  localparam logic [4:0] ST_NORM  = 5'd11;
  localparam logic [4:0] ST_NSQRT = 5'd12;
  localparam logic [4:0] ST_GDIV  = 5'd13;
  localparam logic [4:0] ST_CLASS = 5'd14;
  localparam logic [4:0] ST_WSQ   = 5'd15;
  localparam logic [4:0] ST_ODIV  = 5'd16;
  localparam logic [4:0] ST_KDIV  = 5'd17;
  localparam logic [4:0] ST_RGEN  = 5'd18;
  localparam logic [4:0] ST_EMIT  = 5'd19;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] u;
    u = v;
    return u[15] ? (~u + 16'd1) : u;
  endfunction

  function automatic logic [15:0] mag17(input logic signed [16:0] v);
    logic [16:0] u;
    logic [16:0] n;
    u = v;
    n = ~u + 17'd1;
    return u[16] ? n[15:0] : u[15:0];
  endfunction

  function automatic logic [ABS_W-1:0] mag29(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] u;
    logic [SUM_W-1:0] n;
    u = v;
    n = ~u + SUM_W'(1);
    return u[SUM_W-1] ? n[ABS_W-1:0] : u[ABS_W-1:0];
  endfunction

  logic [4:0]  state;
  logic [3:0]  step;
  logic [1:0]  phase;
  logic [1:0]  ri;
  logic [1:0]  rj;
  logic [1:0]  sel;
  logic        endf;

  logic [CNT_W-1:0]  sample_limit;
  logic [31:0]       variance_limit;
  logic [CNT_W-1:0]  lim;
  logic              take;
  logic              do_clear;

  logic signed [SUM_W-1:0] sums [3];
  logic [SQS_W-1:0]        sumsq;
  logic [CNT_W-1:0]        count;
  logic [15:0]             smp [3];
  logic [ABS_W-1:0]        sum_mag;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  logic [S2_W-1:0]   s2;
  logic [LHS_W-1:0]  lhs;
  logic [ROOT_W-1:0] root;
  logic [RAD_W-1:0]  t;
  logic [4:0]        kshift;
  logic [5:0]        shamt;
  logic [15:0]       mag_q;

  logic signed [15:0] g [3];
  logic signed [16:0] w [3];
  logic [29:0]        w2;
  logic [29:0]        w2eff;
  logic [15:0]        den;
  logic [28:0]        kq [3];
  logic signed [15:0] rot [3][3];
  logic signed [15:0] ka;
  logic signed [15:0] kb;
  logic signed [31:0] oval;
  logic signed [31:0] kxx_s;
  logic signed [31:0] kyy_s;
  logic signed [31:0] kxy_s;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  sga_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sga_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    lim     = (sample_limit > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : sample_limit;
    take    = count < lim;
    sel     = (step[1:0] == 2'd3) ? 2'd0 : step[1:0];
    sum_mag = mag29(sums[sel]);
    shamt   = 6'(kshift) + 6'd15;
    w2eff   = (w2 == '0) ? 30'd1 : w2;
    ka      = (step[1:0] == 2'd1) ? g[1] : g[0];
    kb      = (step[1:0] == 2'd0) ? g[0] : g[1];
    oval    = (w[ri][16] ^ w[rj][16]) ? -32'(div_rsp.quotient[16:0])
                                      : 32'(div_rsp.quotient[16:0]);
    if (ri == rj) begin
      oval = oval - 32'sd16384;
    end
    kxx_s   = 32'(kq[0]);
    kyy_s   = 32'(kq[1]);
    kxy_s   = (g[0][15] ^ g[1][15]) ? -32'(kq[2]) : 32'(kq[2]);
    do_clear = (state == ST_CHECK && count < CNT_W'(MIN_SAMPLES))
            || (state == ST_VCMP && PROD_W'(lhs) > prod)
            || (state == ST_EMIT && step == 4'd2);
  end

  always_comb begin
    unique case (state)
      ST_ACC: begin
        mul_a = MUL_W'(smp[sel]);
        mul_b = MUL_W'(smp[sel]);
      end
      ST_VSQ: begin
        mul_a = MUL_W'(sum_mag);
        mul_b = MUL_W'(sum_mag);
      end
      ST_NS0: begin
        mul_a = MUL_W'(count);
        mul_b = sumsq[31:0];
      end
      ST_NS1: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(sumsq[SQS_W-1:32]);
      end
      ST_NS2: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(count);
      end
      ST_NS3: begin
        mul_a = variance_limit;
        mul_b = prod[MUL_W-1:0];
      end
      ST_WSQ: begin
        mul_a = MUL_W'(mag17(w[sel]));
        mul_b = MUL_W'(mag17(w[sel]));
      end
      ST_ODIV: begin
        mul_a = MUL_W'(mag17(w[ri]));
        mul_b = MUL_W'(mag17(w[rj]));
      end
      ST_KDIV: begin
        mul_a = MUL_W'(mag16(ka));
        mul_b = MUL_W'(mag16(kb));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (rst) begin
      state          <= ST_IDLE;
      step           <= '0;
      phase          <= '0;
      sample_limit   <= 13'd200;
      variance_limit <= 32'd1048576;
      sums[0]        <= '0;
      sums[1]        <= '0;
      sums[2]        <= '0;
      sumsq          <= '0;
      count          <= '0;
      result_valid   <= 1'b0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
    end else begin
      result_valid   <= 1'b0;
      div_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SAMPLE_LIMIT:   sample_limit   <= cfg_data[CNT_W-1:0];
          CFG_VARIANCE_LIMIT: variance_limit <= cfg_data;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            endf   <= batch_end;
            smp[0] <= mag16(accel_x);
            smp[1] <= mag16(accel_y);
            smp[2] <= mag16(accel_z);
            if (take) begin
              sums[0] <= sums[0] + SUM_W'(accel_x);
              sums[1] <= sums[1] + SUM_W'(accel_y);
              sums[2] <= sums[2] + SUM_W'(accel_z);
              count   <= count + 1'b1;
              step    <= '0;
              state   <= ST_ACC;
            end else if (batch_end) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_ACC: begin
          if (step != 4'd0) begin
            sumsq <= sumsq + SQS_W'(prod[31:0]);
          end
          if (step == 4'd3) begin
            step  <= '0;
            state <= endf ? ST_CHECK : ST_IDLE;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_CHECK: begin
          if (count < CNT_W'(MIN_SAMPLES)) begin
            result_valid <= 1'b1;
            status       <= STATUS_FEW;
            magnitude    <= '0;
            row_index    <= '0;
            gravity_part <= '0;
            rot_col0     <= '0;
            rot_col1     <= '0;
            rot_col2     <= '0;
            final_row    <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            s2    <= '0;
            step  <= '0;
            state <= ST_VSQ;
          end
        end
        ST_VSQ: begin
          if (step != 4'd0) begin
            s2 <= s2 + S2_W'(prod[55:0]);
          end
          if (step == 4'd3) begin
            step  <= '0;
            state <= ST_NS0;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_NS0: begin
          state <= ST_NS1;
        end
        ST_NS1: begin
          lhs   <= prod[LHS_W-1:0];
          state <= ST_NS2;
        end
        ST_NS2: begin
          lhs   <= lhs + {prod[25:0], 32'd0} - LHS_W'(s2);
          state <= ST_NS3;
        end
        ST_NS3: begin
          state <= ST_VCMP;
        end
        ST_VCMP: begin
          if (PROD_W'(lhs) > prod) begin
            result_valid <= 1'b1;
            status       <= STATUS_MOVING;
            magnitude    <= '0;
            row_index    <= '0;
            gravity_part <= '0;
            rot_col0     <= '0;
            rot_col1     <= '0;
            rot_col2     <= '0;
            final_row    <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            phase <= '0;
            state <= ST_MSQRT;
          end
        end
        ST_MSQRT: begin
          if (phase == 2'd0) begin
            sqrt_req.start    <= 1'b1;
            sqrt_req.radicand <= RAD_W'(s2);
            phase             <= 2'd1;
          end else if (sqrt_rsp.done) begin
            root  <= sqrt_rsp.root;
            phase <= '0;
            state <= ST_MDIV;
          end
        end
        ST_MDIV: begin
          if (phase == 2'd0) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= DIV_DW'(root);
            div_req.divisor  <= DIV_VW'(count);
            phase            <= 2'd1;
          end else if (div_rsp.done) begin
            mag_q <= (|div_rsp.quotient[DIV_DW-1:16]) ? 16'hFFFF
                                                       : div_rsp.quotient[15:0];
            for (int i = 0; i < 3; i++) begin
              g[i] <= '0;
              for (int j = 0; j < 3; j++) begin
                rot[i][j] <= (i == j) ? ONE_Q14 : 16'sd0;
              end
            end
            phase <= '0;
            step  <= '0;
            if (s2 == '0) begin
              state <= ST_EMIT;
            end else begin
              t      <= RAD_W'(s2);
              kshift <= '0;
              state  <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (t < (RAD_W'(1) << 60)) begin
            t      <= t << 2;
            kshift <= kshift + 5'd1;
          end else begin
            phase <= '0;
            state <= ST_NSQRT;
          end
        end
        ST_NSQRT: begin
          if (phase == 2'd0) begin
            sqrt_req.start    <= 1'b1;
            sqrt_req.radicand <= t;
            phase             <= 2'd1;
          end else if (sqrt_rsp.done) begin
            root  <= sqrt_rsp.root;
            phase <= '0;
            step  <= '0;
            state <= ST_GDIV;
          end
        end
        ST_GDIV: begin
          if (phase == 2'd0) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= (DIV_DW'(sum_mag) << shamt) + DIV_DW'(root);
            div_req.divisor  <= {root[ROOT_W-2:0], 1'b0};
            phase            <= 2'd1;
          end else if (div_rsp.done) begin
            g[sel] <= sums[sel][SUM_W-1] ? -$signed(div_rsp.quotient[15:0])
                                         : $signed(div_rsp.quotient[15:0]);
            phase  <= '0;
            if (step == 4'd2) begin
              step  <= '0;
              state <= ST_CLASS;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        ST_CLASS: begin
          step  <= '0;
          phase <= '0;
          if (g[2] >= ALIGN_MIN) begin
            state <= ST_EMIT;
          end else if (g[2] <= OPPOSE_MAX) begin
            if (mag16(g[0]) <= TILT_MAX) begin
              w[0] <= '0;
              w[1] <= 17'(g[2]);
              w[2] <= -17'(g[1]);
            end else begin
              w[0] <= -17'(g[2]);
              w[1] <= '0;
              w[2] <= 17'(g[0]);
            end
            w2    <= '0;
            state <= ST_WSQ;
          end else begin
            den   <= 16'(ONE_Q14 + g[2]);
            state <= ST_KDIV;
          end
        end
        ST_WSQ: begin
          if (step != 4'd0) begin
            w2 <= w2 + 30'(prod[28:0]);
          end
          if (step == 4'd3) begin
            step  <= '0;
            ri    <= '0;
            rj    <= '0;
            phase <= '0;
            state <= ST_ODIV;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_ODIV: begin
          if (phase == 2'd0) begin
            phase <= 2'd1;
          end else if (phase == 2'd1) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= DIV_DW'({prod[28:0], 15'd0}) + DIV_DW'(w2eff[29:1]);
            div_req.divisor  <= DIV_VW'(w2eff);
            phase            <= 2'd2;
          end else if (div_rsp.done) begin
            rot[ri][rj] <= clamp_q14(oval);
            phase       <= '0;
            if (rj == 2'd2) begin
              rj <= '0;
              if (ri == 2'd2) begin
                step  <= '0;
                state <= ST_EMIT;
              end else begin
                ri <= ri + 2'd1;
              end
            end else begin
              rj <= rj + 2'd1;
            end
          end
        end
        ST_KDIV: begin
          if (phase == 2'd0) begin
            phase <= 2'd1;
          end else if (phase == 2'd1) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= DIV_DW'(prod[28:0]) + DIV_DW'(den[15:1]);
            div_req.divisor  <= DIV_VW'(den);
            phase            <= 2'd2;
          end else if (div_rsp.done) begin
            kq[sel] <= div_rsp.quotient[28:0];
            phase   <= '0;
            if (step == 4'd2) begin
              step  <= '0;
              state <= ST_RGEN;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        ST_RGEN: begin
          rot[0][0] <= clamp_q14(32'sd16384 - kxx_s);
          rot[0][1] <= clamp_q14(-kxy_s);
          rot[0][2] <= clamp_q14(-32'(g[0]));
          rot[1][0] <= clamp_q14(-kxy_s);
          rot[1][1] <= clamp_q14(32'sd16384 - kyy_s);
          rot[1][2] <= clamp_q14(-32'(g[1]));
          rot[2][0] <= clamp_q14(32'(g[0]));
          rot[2][1] <= clamp_q14(32'(g[1]));
          rot[2][2] <= clamp_q14(32'sd16384 - (kxx_s + kyy_s));
          step      <= '0;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          status       <= STATUS_OK;
          magnitude    <= mag_q;
          row_index    <= sel;
          gravity_part <= g[sel];
          rot_col0     <= rot[sel][0];
          rot_col1     <= rot[sel][1];
          rot_col2     <= rot[sel][2];
          final_row    <= (step == 4'd2);
          if (step == 4'd2) begin
            step  <= '0;
            state <= ST_IDLE;
          end else begin
            step <= step + 4'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (do_clear) begin
        sums[0] <= '0;
        sums[1] <= '0;
        sums[2] <= '0;
        sumsq   <= '0;
        count   <= '0;
      end
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond limit");

  a_short_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_OK |-> final_row && row_index == 2'd0)
    else $error("short verdict not a single final result");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_EMIT || state == ST_CHECK || state == ST_VCMP))
    else $error("result strobe from unexpected state");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_rsp.done |-> (state == ST_MSQRT || state == ST_NSQRT))
    else $error("square root finished outside its wait state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_MDIV || state == ST_GDIV ||
                      state == ST_ODIV || state == ST_KDIV))
    else $error("division finished outside its wait state");

endmodule

`default_nettype wire

// ===== hdl/sga_div.sv =====
// ----------------------------------------------------------------------------
// sga_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sga_div import sga_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CW = $clog2(DIV_DW);

  logic              run;
  logic              done;
  logic [CW-1:0]     cnt;
  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dv;
  logic [DIV_DW-1:0] quo;
  logic [DIV_VW:0]   rem_sh;
  logic [DIV_VW:0]   diff;
  logic              fits;

  always_comb begin
    rem_sh = {rem, quo[DIV_DW-1]};
    diff   = rem_sh - {1'b0, dv};
    fits   = rem_sh >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CW'(DIV_DW - 1);
        quo <= req.dividend;
        rem <= '0;
        dv  <= req.divisor;
      end else if (run) begin
        quo <= {quo[DIV_DW-2:0], fits};
        rem <= fits ? diff[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== hdl/sga_sqrt.sv =====
// ----------------------------------------------------------------------------
// sga_sqrt
// Integer square root of a 64-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sga_sqrt import sga_pkg::*; (
  input  wire            clk,
  input  wire            rst,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);

  logic             run;
  logic             done;
  logic [4:0]       idx;
  logic [RAD_W-1:0] x;
  logic [RAD_W-1:0] r;
  logic [RAD_W-1:0] bitv;
  logic [RAD_W-1:0] rb;
  logic             ge;

  always_comb begin
    bitv = RAD_W'(1) << {idx, 1'b0};
    rb   = r + bitv;
    ge   = x >= rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        idx <= 5'd31;
        x   <= req.radicand;
        r   <= '0;
      end else if (run) begin
        if (ge) begin
          x <= x - rb;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        if (idx == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx - 5'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = r[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== tb/sv/static_gravity_alignment_test.sv =====
// ----------------------------------------------------------------------------
// static_gravity_alignment_test
// Drives batches of accelerometer samples through the alignment block with
// random gaps and compares every emitted row against a built-in predictor
// of the averaging, stillness test and gravity-to-Z rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module static_gravity_alignment_test;
  import sga_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic               last;
    int                 gap;
    logic               is_cfg;
    logic               cfg_idx;
    logic [31:0]        cfg_val;
  } request_t;

  typedef struct {
    logic [1:0]         st;
    logic [15:0]        mag;
    logic [1:0]         row;
    logic signed [15:0] grav;
    logic signed [15:0] r0, r1, r2;
    logic               fin;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic batch_end = 1'b0;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic busy, result_valid, final_row;
  logic [1:0] status, row_index;
  logic [15:0] magnitude;
  logic signed [15:0] gravity_part, rot_col0, rot_col1, rot_col2;

  static_gravity_alignment dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t pending_q[$];
  row_t     expected_rows[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       stimulus_done = 0;

  // predictor state
  longint unsigned lim_reg, var_reg;
  longint sx, sy, sz;
  longint unsigned sqs, cnt;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned m, q;
    m = num < 0 ? -num : num;
    q = (m + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat_q14(longint v);
    return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
  endfunction

  task automatic push_verdict(logic [1:0] st);
    row_t r;
    r = '{st, 16'd0, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};
    expected_rows.push_back(r);
  endtask

  task automatic predict_alignment(request_t q);
    longint unsigned lim, n, s2, t, root, mag, m, qq;
    logic [127:0] lhs, rhs;
    longint s[3], g[3], w[3], rot[3][3];
    longint c, den, kxx, kyy, kxy, w2, ax;
    int k;
    row_t r;
    lim = lim_reg > MAX_SAMPLES ? MAX_SAMPLES : lim_reg;
    if (cnt < lim) begin
      sx += q.ax; sy += q.ay; sz += q.az;
      sqs += longint'(q.ax) * longint'(q.ax) + longint'(q.ay) * longint'(q.ay)
           + longint'(q.az) * longint'(q.az);
      cnt++;
    end
    if (!q.last) return;
    n = cnt;
    s[0] = sx; s[1] = sy; s[2] = sz;
    sx = 0; sy = 0; sz = 0; sqs = sqs; 
    if (n < MIN_SAMPLES) begin
      push_verdict(STATUS_FEW);
      sqs = 0; cnt = 0;
      return;
    end
    s2 = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
    lhs = 128'(n) * 128'(sqs) - 128'(s2);
    rhs = 128'(var_reg) * 128'(n * n);
    sqs = 0; cnt = 0;
    if (lhs > rhs) begin
      push_verdict(STATUS_MOVING);
      return;
    end
    mag = int_sqrt(s2) / n;
    if (mag > 65535) mag = 65535;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rot[i][j] = (i == j) ? 16384 : 0;
    g = '{0, 0, 0};
    if (s2 != 0) begin
      t = s2; k = 0;
      while (t < (64'd1 << 60)) begin
        t <<= 2;
        k++;
      end
      root = int_sqrt(t);
      for (int i = 0; i < 3; i++) begin
        m = s[i] < 0 ? -s[i] : s[i];
        qq = ((m << (15 + k)) + root) / (2 * root);
        g[i] = s[i] < 0 ? -longint'(qq) : longint'(qq);
      end
      c = g[2];
      if (10000 * c > 9999 * 16384) begin
      end else if (10000 * c < -9999 * 16384) begin
        ax = g[0] < 0 ? -g[0] : g[0];
        if (10 * ax < 9 * 16384) w = '{0, g[2], -g[1]};
        else w = '{-g[2], 0, g[0]};
        w2 = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
        if (w2 == 0) w2 = 1;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            rot[i][j] = sat_q14(round_div(32768 * w[i] * w[j], w2) - (i == j ? 16384 : 0));
      end else begin
        den = 16384 + c;
        kxx = round_div(g[0] * g[0], den);
        kyy = round_div(g[1] * g[1], den);
        kxy = round_div(g[0] * g[1], den);
        rot[0] = '{sat_q14(16384 - kxx), sat_q14(-kxy), sat_q14(-g[0])};
        rot[1] = '{sat_q14(-kxy), sat_q14(16384 - kyy), sat_q14(-g[1])};
        rot[2] = '{sat_q14(g[0]), sat_q14(g[1]), sat_q14(16384 - (kxx + kyy))};
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.st = STATUS_OK; r.mag = mag[15:0]; r.row = i[1:0];
      r.grav = g[i][15:0];
      r.r0 = rot[i][0][15:0]; r.r1 = rot[i][1][15:0]; r.r2 = rot[i][2][15:0];
      r.fin = (i == 2);
      expected_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // driver
  int gap_left = 0;
  bit have_req = 0;
  bit cfg_hold = 0;
  request_t cur;
  always @(posedge clk) begin
    bit do_cfg;
    do_cfg = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        predict_alignment(cur);
        have_req = 0;
      end
      if (!have_req && pending_q.size() > 0) begin
        if (pending_q[0].is_cfg) begin
          // configuration only when the block is quiet
          if (expected_rows.size() == 0 && !busy && !(start && !busy)) begin
            if (cfg_hold) begin
              cur = pending_q.pop_front();
              do_cfg = 1'b1;
              cfg_index <= cur.cfg_idx;
              cfg_data <= cur.cfg_val;
              if (cur.cfg_idx == CFG_SAMPLE_LIMIT) lim_reg = cur.cfg_val & 32'h1FFF;
              else var_reg = cur.cfg_val;
              cfg_hold = 0;
              gap_left = 0;
            end else if (gap_left == 0) begin
              gap_left = 40;
            end else if (--gap_left == 0) begin
              cfg_hold = 1;
            end
          end
        end else begin
          cur = pending_q.pop_front();
          have_req = 1;
          gap_left = cur.gap;
        end
      end
      if (have_req && gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (have_req) begin
        start <= 1'b1;
        accel_x <= cur.ax; accel_y <= cur.ay; accel_z <= cur.az;
        batch_end <= cur.last;
      end else begin
        start <= 1'b0;
      end
    end
    cfg_write <= do_cfg;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    row_t e;
    if (!rst) begin
      if ((start && !busy) || cfg_write || result_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (result_valid) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_rows.pop_front();
          if (status !== e.st) report_mismatch($sformatf("status %0d exp %0d", status, e.st));
          if (magnitude !== e.mag)
            report_mismatch($sformatf("magnitude %0d exp %0d", magnitude, e.mag));
          if (row_index !== e.row)
            report_mismatch($sformatf("row_index %0d exp %0d", row_index, e.row));
          if (gravity_part !== e.grav)
            report_mismatch($sformatf("gravity_part %0d exp %0d", gravity_part, e.grav));
          if (rot_col0 !== e.r0) report_mismatch($sformatf("rot_col0 %0d exp %0d", rot_col0, e.r0));
          if (rot_col1 !== e.r1) report_mismatch($sformatf("rot_col1 %0d exp %0d", rot_col1, e.r1));
          if (rot_col2 !== e.r2) report_mismatch($sformatf("rot_col2 %0d exp %0d", rot_col2, e.r2));
          if (final_row !== e.fin) report_mismatch($sformatf("final_row %0d exp %0d", final_row, e.fin));
        end
      end
      if (idle_cycles > 5000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add_sample(int x, int y, int z, bit last, bit busy_gaps);
    request_t q;
    q.ax = x; q.ay = y; q.az = z; q.last = last; q.is_cfg = 0;
    q.gap = (busy_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
    pending_q.push_back(q);
  endtask

  task automatic add_write(logic idx, logic [31:0] val);
    request_t q;
    q = '{default: 0};
    q.is_cfg = 1; q.cfg_idx = idx; q.cfg_val = val;
    pending_q.push_back(q);
  endtask

  // still batch around a given vector with noise amplitude
  task automatic add_batch(int n, int gx, int gy, int gz, int noise, bit gaps);
    for (int i = 0; i < n; i++)
      add_sample(gx + $urandom_range(0, 2 * noise) - noise,
                 gy + $urandom_range(0, 2 * noise) - noise,
                 gz + $urandom_range(0, 2 * noise) - noise, i == n - 1, gaps);
  endtask

  initial begin
    int kind, n;
    lim_reg = 200; var_reg = 1048576;
    sx = 0; sy = 0; sz = 0; sqs = 0; cnt = 0;
    // directed: too few, aligned, opposite, zero mean, extremes, moving
    add_batch(3, 0, 0, 10045, 0, 0);
    add_batch(10, 0, 0, 10045, 0, 0);
    add_batch(10, 0, 0, -10045, 0, 0);
    add_batch(10, 0, 0, 0, 0, 0);
    add_batch(10, 32767, -32768, 32767, 0, 0);
    for (int i = 0; i < 10; i++)
      add_sample(i[0] ? 32767 : -32768, i[0] ? -32768 : 32767, 0, i == 9, 0);
    add_write(CFG_SAMPLE_LIMIT, 12);
    add_write(CFG_VARIANCE_LIMIT, 32'hFFFF_FFFF);
    add_batch(15, 30000, -20000, -32768, 5000, 1);
    add_write(CFG_SAMPLE_LIMIT, 0);
    add_batch(12, 100, 100, 100, 0, 0);
    add_write(CFG_SAMPLE_LIMIT, 8191);
    add_write(CFG_VARIANCE_LIMIT, 0);
    add_batch(10, -16000, 700, -9000, 0, 1);
    add_write(CFG_VARIANCE_LIMIT, 1048576);
    add_write(CFG_SAMPLE_LIMIT, 20);
    // random batches: mostly still, some noisy or tilted down
    n = 0;
    while (n < 280) begin
      int sz_b;
      kind = $urandom_range(0, 9);
      sz_b = (kind == 0) ? $urandom_range(1, 9) : $urandom_range(10, 26);
      case (kind)
        1: add_batch(sz_b, $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                     -10045, 30, 1);
        2: add_batch(sz_b, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768, 20000, 1);
        3: add_batch(sz_b, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768, 0, 1);
        default: add_batch(sz_b, $urandom_range(0, 20000) - 10000,
                           $urandom_range(0, 20000) - 10000,
                           $urandom_range(0, 20000) - 10000, $urandom_range(0, 600), 1);
      endcase
      n += sz_b;
      if ($urandom_range(0, 12) == 0)
        add_write(CFG_VARIANCE_LIMIT, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8000000));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !have_req);
    wait (expected_rows.size() == 0);
    repeat (800) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
